// File: rtl/tsqs_pkg.sv
// shared types and constants for the touch sample qualify and scale block
// no dependencies
`default_nettype none

package tsqs_pkg;

    // field widths
    localparam int RAW_W      = 12;
    localparam int VALUE_W    = 13;
    localparam int KIND_W     = 2;
    localparam int PROD_W     = RAW_W + VALUE_W;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 13;
    localparam int ORIENT_W   = 3;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_ABS_X = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABS_Y = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd2;

    // orientation bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    // queued command: a position run or a touch-up
    typedef struct packed {
        logic             touch;
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
    } tsqs_cmd_t;

    // calibration and screen settings
    typedef struct packed {
        logic [RAW_W-1:0]    cal_x_min;
        logic [RAW_W-1:0]    cal_x_max;
        logic [RAW_W-1:0]    cal_y_min;
        logic [RAW_W-1:0]    cal_y_max;
        logic [RAW_W-1:0]    pressure_floor;
        logic [VALUE_W-1:0]  screen_cols;
        logic [VALUE_W-1:0]  screen_rows;
        logic [ORIENT_W-1:0] orientation;
    } tsqs_cfg_t;

endpackage

`default_nettype wire

// File: rtl/touch_sample_qualify_scale_core.sv
// top level of the resistive touch qualify and scale block
// depends on tsqs_pkg, tsqs_front, tsqs_fifo, tsqs_back
//
// One poll of a resistive touch controller enters on the s_ stream: pressure
// Z1/Z2, two X and two Y conversions, and a read-error flag in s_tuser. The
// front end qualifies the poll in the cycle it is taken and tracks the
// pressed flag; work goes through a two-entry queue to the back end.
// A release while pressed yields one touch-up key word; a release while not
// pressed yields nothing. A valid touch yields three words on the m_ stream:
// X-derived position, Y-derived position, and touch-down key (m_tlast set on
// the key word). m_tuser carries the event kind.
// The first word of a touch poll waits on the 25-step bit-serial dividers (one
// per axis, run in parallel); a release word skips the divide. The back end
// takes one command at a time and pops the next once the key word of the last
// is loaded into the output register. The config port is to be written only
// while the block is idle; the block itself does not enforce it.
// Reset (aresetn low, synchronous) clears the queue, the pressed flag and the
// output, and loads the calibration defaults. When m_tready is low the
// output word holds, the back end waits, and s_tready drops once the queue
// fills.
`default_nettype none

module touch_sample_qualify_scale_core
    import tsqs_pkg::*;
#(
    parameter int unsigned STABILITY_LIMIT = 100
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input poll
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [71:0]           s_tdata,  // pressure_one, pressure_two, x_first,
                                                 // y_first, x_second, y_second
    input  wire logic                  s_tuser,  // read_failed
    // output events
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,  // event_value, zero pad
    output logic [KIND_W-1:0]          m_tuser,  // event_kind
    output logic                       m_tlast,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [CFG_ADDR_W-1:0] REG_CAL_X_MIN      = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_X_MAX      = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_Y_MIN      = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_Y_MAX      = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESSURE_FLOOR = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_COLS    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_ROWS    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIENTATION    = 4'd7;

    tsqs_cfg_t          cfg_reg;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    tsqs_cmd_t          push_cmd;
    tsqs_cmd_t          pop_cmd;
    logic [VALUE_W-1:0] out_value;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_x_min      <= '0;
            cfg_reg.cal_x_max      <= {RAW_W{1'b1}};
            cfg_reg.cal_y_min      <= '0;
            cfg_reg.cal_y_max      <= {RAW_W{1'b1}};
            cfg_reg.pressure_floor <= '0;
            cfg_reg.screen_cols    <= '0;
            cfg_reg.screen_rows    <= '0;
            cfg_reg.orientation    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CAL_X_MIN:      cfg_reg.cal_x_min      <= cfg_wdata[RAW_W-1:0];
                REG_CAL_X_MAX:      cfg_reg.cal_x_max      <= cfg_wdata[RAW_W-1:0];
                REG_CAL_Y_MIN:      cfg_reg.cal_y_min      <= cfg_wdata[RAW_W-1:0];
                REG_CAL_Y_MAX:      cfg_reg.cal_y_max      <= cfg_wdata[RAW_W-1:0];
                REG_PRESSURE_FLOOR: cfg_reg.pressure_floor <= cfg_wdata[RAW_W-1:0];
                REG_SCREEN_COLS:    cfg_reg.screen_cols    <= cfg_wdata[VALUE_W-1:0];
                REG_SCREEN_ROWS:    cfg_reg.screen_rows    <= cfg_wdata[VALUE_W-1:0];
                REG_ORIENTATION:    cfg_reg.orientation    <= cfg_wdata[ORIENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tsqs_front #(
        .STABILITY_LIMIT (STABILITY_LIMIT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .q_full         (q_full),
        .read_failed    (s_tuser),
        .pressure_one   (s_tdata[11:0]),
        .pressure_two   (s_tdata[23:12]),
        .x_first        (s_tdata[35:24]),
        .y_first        (s_tdata[47:36]),
        .x_second       (s_tdata[59:48]),
        .y_second       (s_tdata[71:60]),
        .pressure_floor (cfg_reg.pressure_floor),
        .in_ready       (s_tready),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    tsqs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    tsqs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_value};

endmodule

`default_nettype wire

// File: rtl/tsqs_front.sv
// front end: accepts a poll, qualifies it and tracks the pressed flag
// depends on tsqs_pkg
`default_nettype none

module tsqs_front
    import tsqs_pkg::*;
#(
    parameter int unsigned STABILITY_LIMIT = 100
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic               q_full,
    input  wire logic               read_failed,
    input  wire logic [RAW_W-1:0]   pressure_one,
    input  wire logic [RAW_W-1:0]   pressure_two,
    input  wire logic [RAW_W-1:0]   x_first,
    input  wire logic [RAW_W-1:0]   y_first,
    input  wire logic [RAW_W-1:0]   x_second,
    input  wire logic [RAW_W-1:0]   y_second,
    input  wire logic [RAW_W-1:0]   pressure_floor,
    output logic                    in_ready,
    output logic                    push,
    output tsqs_cmd_t               push_cmd
);

    localparam logic [RAW_W-1:0] LIMIT      = RAW_W'(STABILITY_LIMIT);
    localparam logic [RAW_W-1:0] FULL_SCALE = {RAW_W{1'b1}};

    logic             touch_down_reg;
    logic             touch_down_next;
    logic [RAW_W-1:0] gap_x;
    logic [RAW_W-1:0] gap_y;
    logic             release_poll;
    logic             accept;

    // stability gaps between the two readings of each axis
    assign gap_x = (x_first >= x_second) ? (x_first - x_second) : (x_second - x_first);
    assign gap_y = (y_first >= y_second) ? (y_first - y_second) : (y_second - y_first);

    // any failed check makes the poll a release
    assign release_poll = read_failed
        || (pressure_one <= pressure_floor)
        || (pressure_two == '0)
        || (gap_x > LIMIT)
        || (gap_y > LIMIT)
        || (x_first == FULL_SCALE)
        || (y_first == FULL_SCALE);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // a release only queues work when the panel was pressed
    assign push           = accept && (!release_poll || touch_down_reg);
    assign push_cmd.touch = !release_poll;
    assign push_cmd.x_raw = x_first;
    assign push_cmd.y_raw = y_first;

    always_comb begin
        touch_down_next = touch_down_reg;
        if (accept) begin
            touch_down_next = !release_poll;
        end
    end

    // pressed flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_down_reg <= 1'b0;
        end else begin
            touch_down_reg <= touch_down_next;
        end
    end

    a_down_after_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_cmd.touch |=> touch_down_reg)
        else $error("pressed flag not set after a touch");

    a_up_only_when_down: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !push_cmd.touch |-> touch_down_reg)
        else $error("touch-up queued while not pressed");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

// File: rtl/tsqs_fifo.sv
// two-entry command queue between the front and back ends
// depends on tsqs_pkg
`default_nettype none

module tsqs_fifo
    import tsqs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  tsqs_cmd_t      push_cmd,
    input  wire logic      pop,
    output tsqs_cmd_t      pop_cmd,
    output logic           full,
    output logic           empty
);

    localparam int DEPTH = 2;

    tsqs_cmd_t  mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == 2'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: rtl/tsqs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tsqs_pkg
`default_nettype none

module tsqs_div
    import tsqs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [PROD_W-1:0]  dividend,
    input  wire logic [RAW_W-1:0]   divisor,
    output logic                    busy,
    output logic [VALUE_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic [PROD_W-1:0] q_reg;
    logic [RAW_W-1:0]  rem_reg;
    logic [RAW_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              busy_reg;
    logic [RAW_W:0]    trial;
    logic              ge;
    logic [RAW_W:0]    diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, q_reg[PROD_W-1]};
    assign ge    = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    assign busy     = busy_reg;
    assign quotient = q_reg[VALUE_W-1:0];

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(PROD_W - 1);
        end else if (busy_reg) begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient and remainder datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tsqs_back.sv
// back end: calibrates, divides, orients and emits the events of one command
// depends on tsqs_pkg and tsqs_div
`default_nettype none

module tsqs_back
    import tsqs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  tsqs_cfg_t                cfg,
    input  wire logic                q_empty,
    input  tsqs_cmd_t                pop_cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [KIND_W-1:0]        out_kind,
    output logic [VALUE_W-1:0]       out_value,
    output logic                     out_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_X,
        ST_EMIT_Y,
        ST_EMIT_KEY
    } state_t;

    state_t             state_reg;
    tsqs_cmd_t          cmd_reg;
    logic [PROD_W-1:0]  prod_x_reg;
    logic [PROD_W-1:0]  prod_y_reg;
    logic [RAW_W-1:0]   den_x_reg;
    logic [RAW_W-1:0]   den_y_reg;
    logic [VALUE_W-1:0] fixed_x_reg;
    logic [VALUE_W-1:0] fixed_y_reg;
    logic               use_div_x_reg;
    logic               use_div_y_reg;
    logic [VALUE_W-1:0] sx_reg;
    logic [VALUE_W-1:0] sy_reg;
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;

    logic [VALUE_W-1:0] fixed_x_next;
    logic [VALUE_W-1:0] fixed_y_next;
    logic               use_div_x_next;
    logic               use_div_y_next;
    logic [PROD_W-1:0]  prod_x_next;
    logic [PROD_W-1:0]  prod_y_next;
    logic               div_start;
    logic               busy_x;
    logic               busy_y;
    logic [VALUE_W-1:0] quot_x;
    logic [VALUE_W-1:0] quot_y;
    logic [VALUE_W-1:0] vx;
    logic [VALUE_W-1:0] vy;
    logic [VALUE_W-1:0] sx_next;
    logic [VALUE_W-1:0] sy_next;
    logic               out_free;
    logic               swap;

    // clamp or pass through, and flag when the divide result is needed
    function automatic logic [VALUE_W:0] axis_fixed(
        input logic [RAW_W-1:0]   raw,
        input logic [RAW_W-1:0]   lo,
        input logic [RAW_W-1:0]   hi,
        input logic [VALUE_W-1:0] size
    );
        logic [VALUE_W:0] res;
        res = '0;
        if (size == '0 || hi <= lo) begin
            res = {1'b0, 1'b0, raw};
        end else if (raw <= lo) begin
            res = '0;
        end else if (raw >= hi) begin
            res = {1'b0, size - 1'b1};
        end else begin
            res = {1'b1, {VALUE_W{1'b0}}};
        end
        return res;
    endfunction

    // mirrored coordinate, floored at zero
    function automatic logic [VALUE_W-1:0] flip(
        input logic [VALUE_W-1:0] size,
        input logic [VALUE_W-1:0] v
    );
        return (size >= v) ? (size - v) : '0;
    endfunction

    // calibration products, one multiplier per axis
    always_comb begin
        {use_div_x_next, fixed_x_next} =
            axis_fixed(cmd_reg.x_raw, cfg.cal_x_min, cfg.cal_x_max, cfg.screen_cols);
        {use_div_y_next, fixed_y_next} =
            axis_fixed(cmd_reg.y_raw, cfg.cal_y_min, cfg.cal_y_max, cfg.screen_rows);
        prod_x_next = PROD_W'(cmd_reg.x_raw - cfg.cal_x_min)
                      * PROD_W'(cfg.screen_cols - 1'b1);
        prod_y_next = PROD_W'(cmd_reg.y_raw - cfg.cal_y_min)
                      * PROD_W'(cfg.screen_rows - 1'b1);
    end

    assign div_start = (state_reg == ST_DIV_START);

    tsqs_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_x_reg),
        .divisor  (den_x_reg),
        .busy     (busy_x),
        .quotient (quot_x)
    );

    tsqs_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_y_reg),
        .divisor  (den_y_reg),
        .busy     (busy_y),
        .quotient (quot_y)
    );

    // pick divide or clamp result, then apply inversion
    always_comb begin
        vx      = use_div_x_reg ? quot_x : fixed_x_reg;
        vy      = use_div_y_reg ? quot_y : fixed_y_reg;
        sx_next = cfg.orientation[ORIENT_INV_X] ? flip(cfg.screen_cols, vx) : vx;
        sy_next = cfg.orientation[ORIENT_INV_Y] ? flip(cfg.screen_rows, vy) : vy;
    end

    assign swap     = cfg.orientation[ORIENT_SWAP];
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg   <= pop_cmd;
                        state_reg <= pop_cmd.touch ? ST_MUL : ST_EMIT_KEY;
                    end
                end
                ST_MUL: begin
                    prod_x_reg    <= prod_x_next;
                    prod_y_reg    <= prod_y_next;
                    den_x_reg     <= cfg.cal_x_max - cfg.cal_x_min;
                    den_y_reg     <= cfg.cal_y_max - cfg.cal_y_min;
                    fixed_x_reg   <= fixed_x_next;
                    fixed_y_reg   <= fixed_y_next;
                    use_div_x_reg <= use_div_x_next;
                    use_div_y_reg <= use_div_y_next;
                    state_reg     <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (!busy_x && !busy_y) begin
                        sx_reg    <= sx_next;
                        sy_reg    <= sy_next;
                        state_reg <= ST_EMIT_X;
                    end
                end
                ST_EMIT_X: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= swap ? KIND_ABS_Y : KIND_ABS_X;
                        out_value_reg <= sx_reg;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_EMIT_Y;
                    end
                end
                ST_EMIT_Y: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= swap ? KIND_ABS_X : KIND_ABS_Y;
                        out_value_reg <= sy_reg;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_EMIT_KEY;
                    end
                end
                ST_EMIT_KEY: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_KEY;
                        out_value_reg <= {{(VALUE_W-1){1'b0}}, cmd_reg.touch};
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_last_is_key: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_kind_reg == KIND_KEY)
        else $error("final word of a run is not a key event");

    a_key_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg == KIND_KEY |-> out_value_reg[VALUE_W-1:1] == '0)
        else $error("key event value out of range");

    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_START |=> busy_x && busy_y)
        else $error("dividers did not start");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg != ST_IDLE)
        else $error("command popped without leaving idle");

endmodule

`default_nettype wire

// File: test/tb_touch_sample_qualify_scale_core.sv
// self-checking testbench for touch_sample_qualify_scale_core: directed and random polls,
// per-word comparison against an in-bench predictor of qualify, scale, invert and swap
// depends on tsqs_pkg and the rtl of touch_sample_qualify_scale_core
module tb_touch_sample_qualify_scale_core
    import tsqs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_X_MIN      = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_X_MAX      = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_Y_MIN      = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL_Y_MAX      = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESSURE_FLOOR = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_COLS    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_ROWS    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIENTATION    = 4'd7;
    localparam int                    FIRST_UNUSED_REG   = 8;
    localparam int                    LAST_UNUSED_REG    = 15;

    localparam int               STABILITY_LIMIT = 100;
    localparam logic [RAW_W-1:0] FULL_SCALE      = 12'hFFF;
    localparam int               DRAIN_CYCLES    = 40;
    localparam int               CYCLE_LIMIT     = 500000;

    // one expected output word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } touch_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [71:0]           s_tdata   = '0;  // pressure_one, pressure_two, x_first,
                                            // y_first, x_second, y_second
    logic                  s_tuser   = 1'b0;  // read_failed
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;  // event_value, zero pad
    logic [KIND_W-1:0]     m_tuser;  // event_kind
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    tsqs_cfg_t    cfg_model;
    logic         pressed_model;
    touch_event_t expected_events[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    bit quiet          = 1'b0;

    touch_sample_qualify_scale_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_touch_sample_qualify_scale_core NOT OK");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // compare each accepted word with the oldest expectation
    always @(posedge aclk) begin : check_words
        touch_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d value %0d last %0b",
                                          m_tuser, m_tdata, m_tlast));
            end else begin
                want = expected_events.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                if (m_tdata !== {3'b000, want.value})
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              m_tdata, want.value));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
            end
        end
    end

    function automatic logic [RAW_W-1:0] axis_gap(input logic [RAW_W-1:0] a, b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // linear calibration with clamping, raw passthrough when disabled or range empty
    function automatic logic [31:0] scale_axis(input logic [RAW_W-1:0] raw, lo, hi,
                                               input logic [VALUE_W-1:0] size);
        logic [31:0] r, l, h, s;
        r = raw;
        l = lo;
        h = hi;
        s = size;
        if (s == 0 || h <= l) return r;
        if (r <= l) return 0;
        if (r >= h) return s - 1;
        return ((r - l) * (s - 1)) / (h - l);
    endfunction

    // qualify one poll and queue the words it should produce
    function automatic void qualify_poll(input logic failed,
                                         input logic [RAW_W-1:0] z1, z2, x1, y1, x2, y2);
        logic              release_hit;
        logic [31:0]       sx, sy;
        logic [31:0]       cols, rows;
        logic [KIND_W-1:0] kx, ky;
        release_hit = failed || z1 <= cfg_model.pressure_floor || z2 == 0
            || axis_gap(x1, x2) > STABILITY_LIMIT || axis_gap(y1, y2) > STABILITY_LIMIT
            || x1 == FULL_SCALE || y1 == FULL_SCALE;
        if (release_hit) begin
            if (pressed_model) begin
                pressed_model = 1'b0;
                expected_events.push_back({KIND_KEY, 13'd0, 1'b1});
            end
        end else begin
            cols = cfg_model.screen_cols;
            rows = cfg_model.screen_rows;
            sx = scale_axis(x1, cfg_model.cal_x_min, cfg_model.cal_x_max, cfg_model.screen_cols);
            sy = scale_axis(y1, cfg_model.cal_y_min, cfg_model.cal_y_max, cfg_model.screen_rows);
            // inversion floors at zero
            if (cfg_model.orientation[ORIENT_INV_X]) sx = (cols >= sx) ? cols - sx : 0;
            if (cfg_model.orientation[ORIENT_INV_Y]) sy = (rows >= sy) ? rows - sy : 0;
            kx = cfg_model.orientation[ORIENT_SWAP] ? KIND_ABS_Y : KIND_ABS_X;
            ky = cfg_model.orientation[ORIENT_SWAP] ? KIND_ABS_X : KIND_ABS_Y;
            expected_events.push_back({kx, sx[VALUE_W-1:0], 1'b0});
            expected_events.push_back({ky, sy[VALUE_W-1:0], 1'b0});
            expected_events.push_back({KIND_KEY, 13'd1, 1'b1});
            pressed_model = 1'b1;
        end
    endfunction

    // drive one poll, wait for acceptance, predict, then maybe idle
    task automatic send_poll(input logic failed,
                             input logic [RAW_W-1:0] z1, z2, x1, y1, x2, y2);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {y2, x2, y1, x1, z2, z1};
        s_tuser  <= failed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        qualify_poll(failed, z1, z2, x1, y1, x2, y2);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_events.size() != 0);
    endtask

    // block idle: all words in, plus time for a silent release to finish
    task automatic settle_block();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // write every register, junk in the unused upper bits, plus one unused index
    task automatic apply_settings(input tsqs_cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_ADDR_W-1:0] spare;
        junk  = $urandom;
        spare = $urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG);
        write_reg(REG_CAL_X_MIN, {junk[12], c.cal_x_min});
        write_reg(REG_CAL_X_MAX, {junk[12], c.cal_x_max});
        write_reg(REG_CAL_Y_MIN, {junk[12], c.cal_y_min});
        write_reg(REG_CAL_Y_MAX, {junk[12], c.cal_y_max});
        write_reg(REG_PRESSURE_FLOOR, {junk[12], c.pressure_floor});
        write_reg(REG_SCREEN_COLS, c.screen_cols);
        write_reg(REG_SCREEN_ROWS, c.screen_rows);
        write_reg(REG_ORIENTATION, {junk[12:3], c.orientation});
        write_reg(spare, junk);
        cfg_wr_en <= 1'b0;
        cfg_model = c;
    endtask

    function automatic tsqs_cfg_t make_settings(input logic [RAW_W-1:0] xmin, xmax, ymin,
                                                ymax, floor_z,
                                                input logic [VALUE_W-1:0] cols, rows,
                                                input logic [ORIENT_W-1:0] orient);
        tsqs_cfg_t c;
        c.cal_x_min      = xmin;
        c.cal_x_max      = xmax;
        c.cal_y_min      = ymin;
        c.cal_y_max      = ymax;
        c.pressure_floor = floor_z;
        c.screen_cols    = cols;
        c.screen_rows    = rows;
        c.orientation    = orient;
        return c;
    endfunction

    function automatic logic [VALUE_W-1:0] random_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            3:       return 13'h1FFF;
            4:       return $urandom;
            default: return $urandom_range(2, 4096);
        endcase
    endfunction

    function automatic tsqs_cfg_t random_settings();
        tsqs_cfg_t c;
        c = make_settings($urandom_range(0, 1500), $urandom_range(2500, 4095),
                          $urandom_range(0, 1500), $urandom_range(2500, 4095),
                          $urandom_range(0, 300), random_size(), random_size(),
                          $urandom_range(0, 7));
        // occasionally an arbitrary or empty calibration range
        if ($urandom_range(0, 99) < 15) begin
            c.cal_x_min = $urandom;
            c.cal_x_max = $urandom;
        end
        if ($urandom_range(0, 99) < 15) begin
            c.cal_y_min = $urandom;
            c.cal_y_max = $urandom;
        end
        if ($urandom_range(0, 99) < 10) c.pressure_floor = $urandom_range(0, 4000);
        return c;
    endfunction

    // raw reading, biased toward the calibration edges
    function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo, hi);
        int r, v;
        r = $urandom_range(0, 9);
        if (r < 2)      v = int'(lo) + int'($urandom_range(0, 4)) - 2;
        else if (r < 4) v = int'(hi) + int'($urandom_range(0, 4)) - 2;
        else            v = $urandom_range(0, 4094);
        if (v < 0) v = 0;
        if (v > 4094) v = 4094;
        return v;
    endfunction

    // second reading within the stability limit
    function automatic logic [RAW_W-1:0] near_raw(input logic [RAW_W-1:0] a);
        int v;
        v = int'(a) + int'($urandom_range(0, 200)) - STABILITY_LIMIT;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // second reading beyond the stability limit
    function automatic logic [RAW_W-1:0] far_raw(input logic [RAW_W-1:0] a);
        if (a >= 2048) return a - $urandom_range(STABILITY_LIMIT + 1, a);
        return a + $urandom_range(STABILITY_LIMIT + 1, 4095 - a);
    endfunction

    // mostly good touches, some single release causes, some noise
    task automatic send_random_poll();
        logic             failed;
        logic [RAW_W-1:0] z1, z2, x1, y1, x2, y2;
        int               pick;
        pick   = $urandom_range(0, 99);
        failed = 1'b0;
        z1 = (cfg_model.pressure_floor == FULL_SCALE) ? FULL_SCALE
             : $urandom_range(cfg_model.pressure_floor + 1, 4095);
        z2 = $urandom_range(1, 4095);
        x1 = pick_raw(cfg_model.cal_x_min, cfg_model.cal_x_max);
        y1 = pick_raw(cfg_model.cal_y_min, cfg_model.cal_y_max);
        x2 = near_raw(x1);
        y2 = near_raw(y1);
        if (pick >= 92) begin
            {failed, z1, z2, x1, y1, x2, y2} = {$urandom, $urandom, $urandom};
        end else if (pick >= 72) begin
            case ($urandom_range(0, 6))
                0:       failed = 1'b1;
                1:       z1 = $urandom_range(0, cfg_model.pressure_floor);
                2:       z2 = 0;
                3:       x2 = far_raw(x1);
                4:       y2 = far_raw(y1);
                5:       x1 = FULL_SCALE;
                default: y1 = FULL_SCALE;
            endcase
        end
        send_poll(failed, z1, z2, x1, y1, x2, y2);
    endtask

    // release causes with reset settings, raw passthrough
    task automatic test_release_paths();
        send_poll(1, 500, 500, 1000, 1000, 1000, 1000);  // not pressed, silent
        send_poll(0, 1, 1, 0, 0, 0, 0);
        send_poll(1, 500, 500, 1000, 1000, 1000, 1000);  // read error while pressed
        send_poll(0, 4095, 4095, 4094, 4094, 4094, 4094);
        send_poll(0, 0, 500, 1000, 1000, 1000, 1000);    // z1 at the floor
        send_poll(0, 800, 600, 1234, 2345, 1240, 2340);
        send_poll(0, 800, 0, 1234, 2345, 1240, 2340);    // z2 zero
        send_poll(0, 800, 0, 1234, 2345, 1240, 2340);    // already released
    endtask

    task automatic test_stability_and_full_scale();
        send_poll(0, 900, 900, 0, 200, 100, 100);        // both pairs exactly at limit
        send_poll(0, 900, 900, 500, 500, 601, 500);      // x pair one past limit
        send_poll(0, 900, 900, 601, 500, 500, 500);      // other direction, silent
        send_poll(0, 900, 900, 2000, 3000, 2000, 3100);
        send_poll(0, 900, 900, 2000, 3101, 2000, 3000);  // y pair one past limit
        send_poll(0, 900, 900, 3000, 3000, 3000, 3000);
        send_poll(0, 900, 900, 4095, 3000, 4095, 3000);  // x full scale
        send_poll(0, 900, 900, 3000, 3000, 3000, 3000);
        send_poll(0, 900, 900, 3000, 4095, 3000, 4095);  // y full scale
    endtask

    task automatic test_scaling_clamp();
        settle_block();
        apply_settings(make_settings(200, 3900, 300, 3800, 50, 800, 480, 3'b000));
        send_poll(0, 50, 100, 2000, 2000, 2000, 2000);   // z1 equal to floor
        send_poll(0, 51, 100, 199, 300, 199, 300);       // below and at min
        send_poll(0, 4095, 4095, 3900, 4000, 3900, 4000); // at and above max
        send_poll(0, 2000, 2000, 2050, 2050, 2050, 2050);
    endtask

    task automatic test_inversion_and_swap();
        // y unscaled, so its inversion goes negative and floors
        settle_block();
        apply_settings(make_settings(0, 4000, 0, 4095, 0, 640, 0, 3'b110));
        send_poll(0, 700, 700, 4000, 2000, 4000, 2000);
        settle_block();
        apply_settings(make_settings(0, 4000, 0, 4095, 0, 640, 0, 3'b111));
        send_poll(0, 700, 700, 4000, 2000, 4000, 2000);
        // empty x range passes raw through, oversized row count, swap only
        settle_block();
        apply_settings(make_settings(3000, 1000, 0, 4095, 0, 4096, 13'h1FFF, 3'b001));
        send_poll(0, 700, 700, 2500, 4094, 2500, 4094);
    endtask

    task automatic test_register_extremes();
        settle_block();
        apply_settings(make_settings(0, 0, 0, 0, 0, 0, 0, 3'b000));
        repeat (6) send_random_poll();
        settle_block();
        apply_settings(make_settings(4095, 4095, 4095, 4095, 4095, 13'h1FFF, 13'h1FFF, 3'b111));
        repeat (6) send_random_poll();
    endtask

    task automatic test_random_polls();
        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            apply_settings(random_settings());
            quiet = (phase == 2);
            for (int i = 0; i < 50; i++) begin
                send_random_poll();
                if (phase == 3 && i == 25) wait_for_results();
            end
            quiet = 1'b0;
        end
    endtask

    // reset defaults of the predictor
    task automatic reset_model();
        cfg_model     = make_settings(0, 4095, 0, 4095, 0, 0, 0, 3'b000);
        pressed_model = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_release_paths();
        test_stability_and_full_scale();
        test_scaling_clamp();
        test_inversion_and_swap();
        test_register_extremes();
        test_random_polls();
        settle_block();
        if (mismatch_count == 0) begin
            $display("tb_touch_sample_qualify_scale_core OK");
        end else begin
            $display("tb_touch_sample_qualify_scale_core NOT OK");
        end
        $finish;
    end

endmodule

// File: touch_sample_qualify_scale_core.f
rtl/tsqs_pkg.sv
rtl/tsqs_front.sv
rtl/tsqs_fifo.sv
rtl/tsqs_div.sv
rtl/tsqs_back.sv
rtl/touch_sample_qualify_scale_core.sv
test/tb_touch_sample_qualify_scale_core.sv
